// ----- rtl/core/llxyz_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package llxyz_pkg;

  // Field widths
  localparam int LAT_W       = 30;
  localparam int LON_W       = 31;
  localparam int ALT_W       = 40;
  localparam int RAD_W       = 40;
  localparam int OUT_W       = 41;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 128;

  localparam int CORDIC_STAGES_DEF = 24;

  // Internal widths
  localparam int ANG_W  = 32;  // angle folding, Q22 degrees
  localparam int MAG_W  = 29;  // folded angle magnitude
  localparam int ZW     = 44;  // CORDIC angle, Q40 radians
  localparam int XW     = 34;  // CORDIC vector, Q30
  localparam int R_W    = 42;  // radius plus altitude, signed
  localparam int RMAG_W = 41;
  localparam int F_W    = 33;  // Q30 scale factor, signed
  localparam int FMAG_W = 32;
  localparam int P_W    = 68;  // factor product
  localparam int M_W    = 44;  // scaled magnitude

  localparam logic [55:0] DEG2RAD_Q61 = 56'd40244552544872904;
  localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [ANG_W-1:0] TURN_DEG    = 32'sd1509949440;
  localparam logic signed [ANG_W-1:0] HALF_DEG    = 32'sd754974720;
  localparam logic signed [ANG_W-1:0] QUARTER_DEG = 32'sd377487360;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 40'd417997455;

  typedef struct packed {
    logic                  flip;
    logic                  neg;
    logic [MAG_W-1:0]      mag;
  } ang_t;

  typedef struct packed {
    logic                  flip_lat;
    logic                  flip_lon;
    logic signed [R_W-1:0] radius;
  } carry_t;

  // atan(2^-i) in Q40
  function automatic logic [40:0] atan_q40(input int unsigned idx);
    logic [40:0] t;
    case (idx)
      0:       t = 41'hC90FDAA221;
      1:       t = 41'd509785937287;
      2:       t = 41'd269356888665;
      3:       t = 41'd136729762476;
      4:       t = 41'd68630207382;
      5:       t = 41'd34348560106;
      6:       t = 41'd17178471287;
      7:       t = 41'd8589759836;
      8:       t = 41'd4294945451;
      9:       t = 41'd2147480917;
      10:      t = 41'd1073741483;
      11:      t = 41'd536870869;
      12:      t = 41'd268435451;
      13:      t = 41'd134217727;
      default: t = 41'd1 << (40 - idx);
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/llxyz_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none

module llxyz_cordic #(
  parameter int STAGES = llxyz_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic signed [llxyz_pkg::ZW-1:0] z_lat_i,
  input  wire logic signed [llxyz_pkg::ZW-1:0] z_lon_i,
  input  wire llxyz_pkg::carry_t              carry_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [llxyz_pkg::XW-1:0]     cos_lat_o,
  output logic signed [llxyz_pkg::XW-1:0]     sin_lat_o,
  output logic signed [llxyz_pkg::XW-1:0]     cos_lon_o,
  output logic signed [llxyz_pkg::XW-1:0]     sin_lon_o,
  output llxyz_pkg::carry_t                   carry_o
);
  import llxyz_pkg::*;

  // Lane 0 latitude, lane 1 longitude
  logic signed [XW-1:0] x_q [STAGES][2];
  logic signed [XW-1:0] y_q [STAGES][2];
  logic signed [ZW-1:0] z_q [STAGES][2];
  carry_t               carry_q [STAGES];
  logic                 v_q [STAGES];
  logic                 rdy [STAGES+1];

  assign rdy[STAGES] = out_ready_i;
  assign in_ready_o  = rdy[0];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q40(s));
    logic signed [XW-1:0] xi [2];
    logic signed [XW-1:0] yi [2];
    logic signed [ZW-1:0] zi [2];
    carry_t               ci;
    logic                 vi;

    if (s == 0) begin : g_first
      assign xi[0] = GAIN_Q30;
      assign xi[1] = GAIN_Q30;
      assign yi[0] = '0;
      assign yi[1] = '0;
      assign zi[0] = z_lat_i;
      assign zi[1] = z_lon_i;
      assign ci    = carry_i;
      assign vi    = in_valid_i;
    end else begin : g_next
      assign xi[0] = x_q[s-1][0];
      assign xi[1] = x_q[s-1][1];
      assign yi[0] = y_q[s-1][0];
      assign yi[1] = y_q[s-1][1];
      assign zi[0] = z_q[s-1][0];
      assign zi[1] = z_q[s-1][1];
      assign ci    = carry_q[s-1];
      assign vi    = v_q[s-1];
    end

    assign rdy[s] = !v_q[s] || rdy[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= vi;
      end
    end

    // Rotate toward zero residual angle
    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        carry_q[s] <= ci;
        for (int l = 0; l < 2; l++) begin
          if (!zi[l][ZW-1]) begin
            x_q[s][l] <= xi[l] - (yi[l] >>> s);
            y_q[s][l] <= yi[l] + (xi[l] >>> s);
            z_q[s][l] <= zi[l] - ATAN;
          end else begin
            x_q[s][l] <= xi[l] + (yi[l] >>> s);
            y_q[s][l] <= yi[l] - (xi[l] >>> s);
            z_q[s][l] <= zi[l] + ATAN;
          end
        end
      end
    end
  end

  assign out_valid_o = v_q[STAGES-1];
  assign cos_lat_o   = x_q[STAGES-1][0];
  assign sin_lat_o   = y_q[STAGES-1][0];
  assign cos_lon_o   = x_q[STAGES-1][1];
  assign sin_lon_o   = y_q[STAGES-1][1];
  assign carry_o     = carry_q[STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/core/lat_lon_alt_to_xyz.sv -----
// Pipeline: the front-end stages, the CORDIC stages, the back-end stages and the output register, in that order.
// Throughput: one transaction per cycle while the master side does not stall; the CORDIC stages, multipliers and output
// register each take a new transaction in every cycle in which they are ready.
// Each stage holds its own valid bit, so a stall fills bubbles before it halts input.
// Reset: asynchronous, active low; clears all valid bits and loads the reset radius.
`timescale 1ns / 1ps
`default_nettype none

module lat_lon_alt_to_xyz #(
  parameter int CORDIC_STAGES = llxyz_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration: earth radius, Q24.16 km
  input  wire logic                              cfg_we_i,
  input  wire logic [llxyz_pkg::RAD_W-1:0]       cfg_wdata_i,
  // slave side
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // latitude [29:0], longitude [60:30], altitude [100:61], zeros above
  input  wire logic [llxyz_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // master side
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // pos_x [40:0], pos_y [81:41], pos_z [122:82], zeros above
  output logic [llxyz_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o
);
  import llxyz_pkg::*;

  localparam logic signed [P_W-1:0] HALF_Q30 = P_W'(536870912);
  localparam logic [73:0]           RND_Q30  = 74'd536870912;
  localparam logic [M_W-1:0]        POS_LIM  = M_W'(1) << (OUT_W - 1);
  localparam logic [OUT_W-1:0]      OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0]      OUT_MIN  = {1'b1, {(OUT_W-1){1'b0}}};

  // Fold an angle into [-90, 90] degrees; flip marks a half-turn shift.
  function automatic ang_t fold_angle(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] r;
    ang_t o;
    r = a;
    if (r >= HALF_DEG) begin
      r = r - TURN_DEG;
    end else if (r < -HALF_DEG) begin
      r = r + TURN_DEG;
    end
    o.flip = 1'b0;
    if (r > QUARTER_DEG) begin
      r = r - HALF_DEG;
      o.flip = 1'b1;
    end else if (r < -QUARTER_DEG) begin
      r = r + HALF_DEG;
      o.flip = 1'b1;
    end
    o.neg = r[ANG_W-1];
    o.mag = MAG_W'(o.neg ? -r : r);
    return o;
  endfunction

  // Radius register
  logic [RAD_W-1:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // Unpack the slave transaction
  logic signed [LAT_W-1:0] in_lat;
  logic signed [LON_W-1:0] in_lon;
  logic signed [ALT_W-1:0] in_alt;

  assign in_lat = s_axis_tdata_i[LAT_W-1:0];
  assign in_lon = s_axis_tdata_i[LAT_W+LON_W-1:LAT_W];
  assign in_alt = s_axis_tdata_i[LAT_W+LON_W+ALT_W-1:LAT_W+LON_W];

  // Ready chain: a stage loads when it is empty or its successor loads
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8, rdy9, rdy_out;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, vo_q;
  logic cor_ready, cor_valid;

  // Stage 1: fold angles, form R
  ang_t                  lat1_q, lon1_q;
  logic signed [R_W-1:0] r1_q;
  // Stage 2: degree to radian partial products
  logic [56:0]           ph2_q [2];
  logic [56:0]           pl2_q [2];
  logic                  neg2_q [2];
  carry_t                carry2_q;
  // Stage 3: signed Q40 angle
  logic signed [ZW-1:0]  z3_q [2];
  carry_t                carry3_q;
  // CORDIC outputs
  logic signed [XW-1:0]  cor_clat, cor_slat, cor_clon, cor_slon;
  carry_t                cor_carry;
  // Stage 4: quadrant correction
  logic signed [XW-1:0]  clat4_q, slat4_q, clon4_q, slon4_q;
  logic signed [R_W-1:0] r4_q;
  // Stage 5: factor products
  logic signed [P_W-1:0] p5_q [2];
  logic signed [XW-1:0]  slat5_q;
  logic signed [R_W-1:0] r5_q;
  // Stage 6: Q30 factors for x, y, z
  logic signed [F_W-1:0] f6_q [3];
  logic signed [R_W-1:0] r6_q;
  // Stage 7: magnitudes
  logic [RMAG_W-1:0]     rm7_q;
  logic [FMAG_W-1:0]     fm7_q [3];
  logic                  neg7_q [3];
  // Stage 8: radius partial products
  logic [52:0]           ph8_q [3];
  logic [51:0]           pl8_q [3];
  logic                  neg8_q [3];
  // Stage 9: rounded magnitude
  logic [M_W-1:0]        m9_q [3];
  logic                  neg9_q [3];
  // Output register
  logic [OUT_W-1:0]      pos_q [3];

  assign rdy_out = !vo_q || m_axis_tready_i;
  assign rdy9    = !v9_q || rdy_out;
  assign rdy8    = !v8_q || rdy9;
  assign rdy7    = !v7_q || rdy8;
  assign rdy6    = !v6_q || rdy7;
  assign rdy5    = !v5_q || rdy6;
  assign rdy4    = !v4_q || rdy5;
  assign rdy3    = !v3_q || cor_ready;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;

  assign s_axis_tready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1)    v1_q <= s_axis_tvalid_i;
      if (rdy2)    v2_q <= v1_q;
      if (rdy3)    v3_q <= v2_q;
      if (rdy4)    v4_q <= cor_valid;
      if (rdy5)    v5_q <= v4_q;
      if (rdy6)    v6_q <= v5_q;
      if (rdy7)    v7_q <= v6_q;
      if (rdy8)    v8_q <= v7_q;
      if (rdy9)    v9_q <= v8_q;
      if (rdy_out) vo_q <= v9_q;
    end
  end

  // Front end: fold, convert to radians
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      lat1_q <= fold_angle(ANG_W'(in_lat));
      lon1_q <= fold_angle(ANG_W'(in_lon));
      r1_q   <= R_W'(in_alt) + R_W'($signed({1'b0, radius_q}));
    end
    if (rdy2) begin
      ph2_q[0]          <= 57'(lat1_q.mag) * 57'(DEG2RAD_Q61[55:28]);
      pl2_q[0]          <= 57'(lat1_q.mag) * 57'(DEG2RAD_Q61[27:0]);
      ph2_q[1]          <= 57'(lon1_q.mag) * 57'(DEG2RAD_Q61[55:28]);
      pl2_q[1]          <= 57'(lon1_q.mag) * 57'(DEG2RAD_Q61[27:0]);
      neg2_q[0]         <= lat1_q.neg;
      neg2_q[1]         <= lon1_q.neg;
      carry2_q.flip_lat <= lat1_q.flip;
      carry2_q.flip_lon <= lon1_q.flip;
      carry2_q.radius   <= r1_q;
    end
    if (rdy3) begin
      carry3_q <= carry2_q;
      for (int l = 0; l < 2; l++) begin
        logic [85:0]          sum;
        logic signed [ZW-1:0] rad;
        sum = {1'b0, ph2_q[l], 28'd0} + 86'(pl2_q[l]);
        rad = $signed({1'b0, sum[85:43]});
        z3_q[l] <= neg2_q[l] ? -rad : rad;
      end
    end
  end

  llxyz_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v3_q),
    .in_ready_o  (cor_ready),
    .z_lat_i     (z3_q[0]),
    .z_lon_i     (z3_q[1]),
    .carry_i     (carry3_q),
    .out_valid_o (cor_valid),
    .out_ready_i (rdy4),
    .cos_lat_o   (cor_clat),
    .sin_lat_o   (cor_slat),
    .cos_lon_o   (cor_clon),
    .sin_lon_o   (cor_slon),
    .carry_o     (cor_carry)
  );

  // Back end: factors, scaling by R, saturation
  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      // Negate both terms when the angle was shifted by a half turn
      clat4_q <= cor_carry.flip_lat ? -cor_clat : cor_clat;
      slat4_q <= cor_carry.flip_lat ? -cor_slat : cor_slat;
      clon4_q <= cor_carry.flip_lon ? -cor_clon : cor_clon;
      slon4_q <= cor_carry.flip_lon ? -cor_slon : cor_slon;
      r4_q    <= cor_carry.radius;
    end
    if (rdy5) begin
      p5_q[0] <= P_W'(clat4_q) * P_W'(clon4_q);
      p5_q[1] <= P_W'(clat4_q) * P_W'(slon4_q);
      slat5_q <= slat4_q;
      r5_q    <= r4_q;
    end
    if (rdy6) begin
      for (int l = 0; l < 2; l++) begin
        logic signed [P_W-1:0] t;
        t = p5_q[l] + HALF_Q30;
        f6_q[l] <= t[30+F_W-1:30];
      end
      f6_q[2] <= F_W'(slat5_q);
      r6_q    <= r5_q;
    end
    if (rdy7) begin
      rm7_q <= RMAG_W'(r6_q[R_W-1] ? -r6_q : r6_q);
      for (int l = 0; l < 3; l++) begin
        fm7_q[l]  <= FMAG_W'(f6_q[l][F_W-1] ? -f6_q[l] : f6_q[l]);
        neg7_q[l] <= r6_q[R_W-1] ^ f6_q[l][F_W-1];
      end
    end
    if (rdy8) begin
      for (int l = 0; l < 3; l++) begin
        ph8_q[l]  <= 53'(rm7_q[40:20]) * 53'(fm7_q[l]);
        pl8_q[l]  <= 52'(rm7_q[19:0]) * 52'(fm7_q[l]);
        neg8_q[l] <= neg7_q[l];
      end
    end
    if (rdy9) begin
      for (int l = 0; l < 3; l++) begin
        logic [73:0] sum;
        sum = {1'b0, ph8_q[l], 20'd0} + 74'(pl8_q[l]) + RND_Q30;
        m9_q[l]   <= sum[73:30];
        neg9_q[l] <= neg8_q[l];
      end
    end
    if (rdy_out) begin
      // Clamp the magnitude to the signed output range, then apply the sign
      for (int l = 0; l < 3; l++) begin
        if (!neg9_q[l]) begin
          pos_q[l] <= (m9_q[l] >= POS_LIM) ? OUT_MAX : m9_q[l][OUT_W-1:0];
        end else begin
          pos_q[l] <= (m9_q[l] >= POS_LIM) ? OUT_MIN : -m9_q[l][OUT_W-1:0];
        end
      end
    end
  end

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-3*OUT_W){1'b0}}, pos_q[2], pos_q[1], pos_q[0]};

  // An empty output register lets the whole chain load
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("slave side stalled with empty output register");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> v1_q)
    else $error("accepted transaction missing from first stage");

  a_last_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v9_q && !vo_q) |=> vo_q)
    else $error("last stage did not advance into empty output register");

endmodule

`default_nettype wire

// ----- dv/lat_lon_alt_to_xyz_checker.sv -----
`timescale 1ns / 1ps

module lat_lon_alt_to_xyz_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [39:0]  cfg_wdata_i,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [103:0] s_tdata_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [127:0] m_tdata_i,
  output int           errors_o,
  output int           pending_o
);
  localparam int STAGES = llxyz_pkg::CORDIC_STAGES_DEF;
  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
  localparam longint TURN = 64'sd1509949440;
  localparam longint HALF = 64'sd754974720;
  localparam longint QUART = 64'sd377487360;
  localparam longint POS_MAX = 64'sd1099511627775;
  localparam longint POS_MIN = -POS_MAX - 1;

  typedef struct packed {
    logic [40:0] x;
    logic [40:0] y;
    logic [40:0] z;
  } xyz_t;

  xyz_t        xyz_q[$];
  logic [39:0] radius;
  longint      arctan_tbl[STAGES];

  function automatic longint arctan_entry(input int i);
    longint s;
    logic [63:0] t;
    s = 0;
    if (i == 0) s = longint'(PI_Q61 >> 1);
    else
      for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
        t = (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
        if (k % 2) s -= longint'(t);
        else s += longint'(t);
      end
    return (s + (64'sd1 << 21)) >>> 22;
  endfunction

  // CORDIC sine/cosine of an angle in Q22 degrees, results in Q30
  function automatic void rotate(input longint deg, output longint c, output longint sn);
    longint a, z, x, y, nx;
    logic flip;
    logic [127:0] prod;
    a = deg % TURN;
    flip = 0;
    if (a >= HALF) a -= TURN;
    else if (a < -HALF) a += TURN;
    if (a > QUART) begin
      a -= HALF;
      flip = 1;
    end else if (a < -QUART) begin
      a += HALF;
      flip = 1;
    end
    prod = 128'(a < 0 ? -a : a) * 128'(PI_Q61 / 180);
    z = longint'(prod >> 43);
    if (a < 0) z = -z;
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_tbl[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_tbl[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic logic [40:0] scale_sat(input longint r, input longint f);
    logic [127:0] m;
    longint v;
    m = (128'(r < 0 ? -r : r) * 128'(f < 0 ? -f : f) + (128'd1 << 29)) >> 30;
    if (m > 128'(POS_MAX) + 1) m = 128'(POS_MAX) + 1;
    v = ((r < 0) != (f < 0)) ? -longint'(m) : longint'(m);
    if (v > POS_MAX) v = POS_MAX;
    if (v < POS_MIN) v = POS_MIN;
    return v[40:0];
  endfunction

  function automatic xyz_t predict_xyz(input logic [103:0] d);
    longint lat, lon, alt, r, clat, slat, clon, slon;
    xyz_t o;
    lat = longint'(signed'(d[29:0]));
    lon = longint'(signed'(d[60:30]));
    alt = longint'(signed'(d[100:61]));
    r = alt + longint'({24'd0, radius});
    rotate(lat, clat, slat);
    rotate(lon, clon, slon);
    o.x = scale_sat(r, (clat * clon + (64'sd1 << 29)) >>> 30);
    o.y = scale_sat(r, (clat * slon + (64'sd1 << 29)) >>> 30);
    o.z = scale_sat(r, slat);
    return o;
  endfunction

  initial begin
    errors_o = 0;
    for (int i = 0; i < STAGES; i++) arctan_tbl[i] = arctan_entry(i);
  end

  assign pending_o = xyz_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    xyz_t want;
    if (!rst_ni) begin
      radius <= 40'd417997455;
      xyz_q.delete();
    end else begin
      if (cfg_we_i) radius <= cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) xyz_q.push_back(predict_xyz(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        if (xyz_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected transaction, actual %h", $time, m_tdata_i);
        end else begin
          want = xyz_q.pop_front();
          if (m_tdata_i[40:0] !== want.x) begin
            errors_o++;
            $display("%0t: pos_x expected %h actual %h", $time, want.x, m_tdata_i[40:0]);
          end
          if (m_tdata_i[81:41] !== want.y) begin
            errors_o++;
            $display("%0t: pos_y expected %h actual %h", $time, want.y, m_tdata_i[81:41]);
          end
          if (m_tdata_i[122:82] !== want.z) begin
            errors_o++;
            $display("%0t: pos_z expected %h actual %h", $time, want.z, m_tdata_i[122:82]);
          end
          if (m_tdata_i[127:123] !== 5'd0) begin
            errors_o++;
            $display("%0t: pad expected 0 actual %h", $time, m_tdata_i[127:123]);
          end
        end
      end
    end
  end
endmodule

// ----- dv/lat_lon_alt_to_xyz_tb.sv -----
`timescale 1ns / 1ps

module lat_lon_alt_to_xyz_tb;
  localparam longint LAT_MAX = 377487360;
  localparam longint LON_MAX = 754974720;
  localparam longint ALT_MIN = -655360;
  localparam longint ALT_MAX = 549755813887;
  localparam int     DRAIN = llxyz_pkg::CORDIC_STAGES_DEF + 16;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [39:0]  cfg_wdata;
  logic         s_tvalid, s_tready;
  logic [103:0] s_tdata;
  logic         m_tvalid, m_tready;
  logic [127:0] m_tdata;
  int           errors, pending;
  int           src_idle_pct, dst_idle_pct;
  int           holdoff_req, holdoff_done;

  lat_lon_alt_to_xyz uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_o(m_tdata)
  );

  lat_lon_alt_to_xyz_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("lat_lon_alt_to_xyz_tb NOT OK");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    int hold;
    m_tready = 0;
    holdoff_done = 0;
    forever begin
      @(posedge clk);
      if (holdoff_req != holdoff_done) begin
        hold = 300;
        holdoff_done = holdoff_req;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 0;
      end else m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Offer one transaction, holding it until the block takes it
  task automatic send_item(input longint lat, input longint lon, input longint alt);
    logic go;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {3'b0, alt[39:0], lon[30:0], lat[29:0]};
    do begin
      @(negedge clk);
      go = s_tready;
      @(posedge clk);
    end while (!go);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_radius(input logic [39:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic longint pick_angle(input longint lim);
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? lim - $urandom_range(3) : -lim + $urandom_range(3);
      1:       return longint'($urandom_range(2000)) - 1000;
      default: return longint'($urandom_range(2 * lim)) - lim;
    endcase
  endfunction

  function automatic longint pick_alt();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? ALT_MAX : ALT_MIN;
      1, 2:    return ALT_MIN + longint'(r % 64'(ALT_MAX - ALT_MIN + 1));
      default: return longint'($urandom_range(32'h0400_0000)) + ALT_MIN;
    endcase
  endfunction

  initial begin
    logic [39:0] radii[6];
    radii = '{40'd0, 40'hFF_FFFF_FFFF, 40'd417522073, 40'd0, 40'd417997455, 40'd1};
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    s_tvalid = 0;
    s_tdata = 0;
    holdoff_req = 0;
    src_idle_pct = 14;
    dst_idle_pct = 74;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: pole and antimeridian extremes, quadrant folds, altitude limits
    send_item(0, 0, 0);
    send_item(LAT_MAX, 0, 0);
    send_item(-LAT_MAX, 0, 0);
    send_item(0, LON_MAX, 0);
    send_item(0, -LON_MAX, 0);
    send_item(0, LAT_MAX, 0);
    send_item(0, -LAT_MAX, 0);
    send_item(0, LAT_MAX + 1, 0);
    send_item(0, -LAT_MAX - 1, 0);
    send_item(LAT_MAX / 2, LON_MAX / 2, ALT_MAX);
    send_item(-LAT_MAX / 2, -LON_MAX / 2, ALT_MIN);
    send_item(1, -1, 1);
    send_item(-1, 1, -1);
    send_item(LAT_MAX, LON_MAX, ALT_MAX);
    send_item(-LAT_MAX, -LON_MAX, ALT_MIN);
    drain();

    radii[3] = 40'({$urandom, $urandom});
    for (int ph = 0; ph < 6; ph++) begin
      write_radius(radii[ph]);
      case (ph / 2)
        0: begin src_idle_pct = 14; dst_idle_pct = 74; end
        1: begin src_idle_pct = 74; dst_idle_pct = 14; end
        default: begin src_idle_pct = 0; dst_idle_pct = 0; end
      endcase
      // Fill the pipeline against a stalled receiver
      if (ph == 4) holdoff_req++;
      for (int n = 0; n < 125; n++)
        send_item(pick_angle(LAT_MAX), pick_angle(LON_MAX), pick_alt());
      drain();
    end

    if (errors == 0) $display("lat_lon_alt_to_xyz_tb OK");
    else $display("lat_lon_alt_to_xyz_tb NOT OK");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/llxyz_pkg.sv
rtl/core/llxyz_cordic.sv
rtl/core/lat_lon_alt_to_xyz.sv
dv/lat_lon_alt_to_xyz_checker.sv
dv/lat_lon_alt_to_xyz_tb.sv
